[rtl/core/kei_pkg.sv]
package kei_pkg;

  localparam int unsigned FX_ONE = 65536;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic CFG_KEY_COUNT = 1'b0;
  localparam logic CFG_VALUE_KIND = 1'b1;

  localparam logic [2:0] KIND_SCALAR = 3'd0;
  localparam logic [2:0] KIND_VEC4 = 3'd3;
  localparam logic [2:0] KIND_BOOL = 3'd4;

  localparam logic [2:0] CRV_LINEAR = 3'd0;
  localparam logic [2:0] CRV_SMOOTH = 3'd1;
  localparam logic [2:0] CRV_IN = 3'd2;
  localparam logic [2:0] CRV_OUT = 3'd3;
  localparam logic [2:0] CRV_INOUT = 3'd4;
  localparam logic [2:0] CRV_BOUNCE = 3'd5;
  localparam logic [2:0] CRV_ELASTIC = 3'd6;

  typedef struct packed {
    logic        action;
    logic [5:0]  key_index;
    logic [31:0] key_time;
    logic [2:0]  key_curve;
    logic signed [31:0] key_value_0;
    logic signed [31:0] key_value_1;
    logic signed [31:0] key_value_2;
    logic signed [31:0] key_value_3;
    logic [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_0;
    logic signed [31:0] result_1;
    logic signed [31:0] result_2;
    logic signed [31:0] result_3;
    logic        track_empty;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      key_time;
    logic [2:0]       key_curve;
    logic [3:0][31:0] values;
  } key_entry_t;

  // Sine of a Q30 phase over four quadrants, answered in signed Q1.16. Used at
  // elaboration only, to fill the sine table.
  function automatic logic signed [17:0] sine_sample(input logic [63:0] q);
    logic [63:0] quad;
    logic [63:0] f;
    logic [63:0] g;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic signed [17:0] s;
    quad = (q >> 30) & 64'd3;
    f = q & (Q30_ONE - 64'd1);
    g = quad[0] ? (Q30_ONE - f) : f;
    x = (g * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    r = Q30_ONE;
    r = Q30_ONE - ((x2 * r) >> 30) / 64'd156;
    r = Q30_ONE - ((x2 * r) >> 30) / 64'd110;
    r = Q30_ONE - ((x2 * r) >> 30) / 64'd72;
    r = Q30_ONE - ((x2 * r) >> 30) / 64'd42;
    r = Q30_ONE - ((x2 * r) >> 30) / 64'd20;
    r = Q30_ONE - ((x2 * r) >> 30) / 64'd6;
    r = (((x * r) >> 30) + 64'd8192) >> 14;
    if (r > 64'd65536) begin
      r = 64'd65536;
    end
    s = 18'(r);
    return quad[1] ? -s : s;
  endfunction

endpackage

[rtl/core/kei_mem.sv]
module kei_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  kei_pkg::key_entry_t    wr_data,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output kei_pkg::key_entry_t    rd_data
);

  kei_pkg::key_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/kei_div.sv]
module kei_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [16:0] quo
);

  // Restoring division of num * 2^16 by den, one quotient bit per cycle.
  // The caller guarantees num <= den, so 17 bits hold the quotient.
  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] den_r;
  logic [16:0] quo_r;
  logic        done_r;
  logic        ge;
  logic [32:0] rem_sub;

  assign ge = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  assign done = done_r;
  assign quo = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd16);
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r <= 5'd0;
        rem_r <= {1'b0, num};
        den_r <= den;
      end else if (busy_r) begin
        quo_r <= {quo_r[15:0], ge};
        rem_r <= {rem_sub[31:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd16) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/core/kei_curve.sv]
module kei_curve #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         code,
  input  logic [16:0]        t,
  output logic               done,
  output logic signed [17:0] c
);

  localparam int SW = $clog2(SINE_TABLE_DEPTH);
  localparam int XW = SW + 3;
  localparam int PW = 17 + XW;
  localparam logic [XW-1:0] D1 = XW'(SINE_TABLE_DEPTH);
  localparam logic [XW-1:0] D2 = XW'(2 * SINE_TABLE_DEPTH);
  localparam logic [XW-1:0] D4 = XW'(4 * SINE_TABLE_DEPTH);
  localparam logic [16:0] ONE17 = 17'd65536;
  localparam logic [16:0] HALF17 = 17'd32768;
  localparam logic signed [19:0] ONE20 = 20'sd65536;

  typedef enum logic [2:0] {
    C_IDLE, C_IDX, C_MOD, C_ROM, C_MUL1, C_MUL2, C_FIN
  } cstate_t;

  // One period of sine, sampled at SINE_TABLE_DEPTH points.
  logic signed [17:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] PHASE = ((64'(k) * 64'd4) << 30) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = kei_pkg::sine_sample(PHASE);
  end

  cstate_t            state_r;
  logic [2:0]         code_r;
  logic [16:0]        t_r;
  logic [XW-1:0]      x_r;
  logic [SW-1:0]      idx_r;
  logic signed [17:0] s_r;
  logic [33:0]        p1_r;
  logic [36:0]        p2_r;
  logic signed [17:0] c_r;
  logic               done_r;

  logic [XW-1:0]      mul_k;
  logic [PW-1:0]      x_prod;
  logic [XW-1:0]      m1, m2, m3;
  logic [16:0]        u;
  logic [16:0]        s_abs;
  logic [16:0]        op_a, op_b;
  logic [18:0]        k3;
  logic signed [19:0] tt, p16, p15, c_w;

  assign mul_k = (code_r == kei_pkg::CRV_ELASTIC) ? D4 : D2;
  assign x_prod = (PW'(t_r) * PW'(mul_k)) >> 16;
  assign m1 = (x_r >= D2) ? (x_r - D2) : x_r;
  assign m2 = (m1 >= D2) ? (m1 - D2) : m1;
  assign m3 = (m2 >= D1) ? (m2 - D1) : m2;
  assign u = ONE17 - t_r;
  assign s_abs = s_r[17] ? 17'(-s_r) : 17'(s_r);
  assign k3 = 19'd196608 - {1'b0, t_r, 1'b0};
  assign tt = 20'(t_r);
  assign p16 = 20'(p1_r >> 16);
  assign p15 = 20'(p1_r >> 15);

  always_comb begin
    unique case (code_r)
      kei_pkg::CRV_OUT: begin
        op_a = u;
        op_b = u;
      end
      kei_pkg::CRV_INOUT: begin
        op_a = (t_r < HALF17) ? t_r : u;
        op_b = (t_r < HALF17) ? t_r : u;
      end
      kei_pkg::CRV_BOUNCE, kei_pkg::CRV_ELASTIC: begin
        op_a = s_abs;
        op_b = u;
      end
      default: begin
        op_a = t_r;
        op_b = t_r;
      end
    endcase
  end

  always_comb begin
    unique case (code_r)
      kei_pkg::CRV_SMOOTH: c_w = 20'(p2_r >> 16);
      kei_pkg::CRV_IN:     c_w = p16;
      kei_pkg::CRV_OUT:    c_w = ONE20 - p16;
      kei_pkg::CRV_INOUT:  c_w = (t_r < HALF17) ? p15 : (ONE20 - p15);
      kei_pkg::CRV_BOUNCE: c_w = ONE20 - p16;
      kei_pkg::CRV_ELASTIC: c_w = s_r[17] ? (tt - p16) : (tt + p16);
      default:             c_w = tt;
    endcase
  end

  assign done = done_r;
  assign c = c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (state_r == C_FIN);
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            t_r <= t;
            code_r <= code;
            state_r <= C_IDX;
          end
        end
        C_IDX: begin
          x_r <= XW'(x_prod);
          state_r <= C_MOD;
        end
        C_MOD: begin
          idx_r <= SW'(m3);
          state_r <= C_ROM;
        end
        C_ROM: begin
          s_r <= sine_rom[idx_r];
          state_r <= C_MUL1;
        end
        C_MUL1: begin
          p1_r <= 34'(op_a) * 34'(op_b);
          state_r <= C_MUL2;
        end
        C_MUL2: begin
          p2_r <= 37'(p1_r >> 16) * 37'(k3);
          state_r <= C_FIN;
        end
        C_FIN: begin
          c_r <= 18'(c_w);
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/keyframe_easing_interpolator.sv]
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   kei_pkg::in_item_t (keyframe write or query)
// out_      output     out_valid / out_ready kei_pkg::out_item_t (one per query)
// cfg_      input      cfg_we                cfg_index selects key_count or value_kind
//
// A keyframe write lands in the key memory in the cycle it is accepted and has no result.
// A query scans one slot per cycle up to the first key at or past the query time; a span
// then uses the 17-bit divider, the curve unit and one multiply per lane (none for
// booleans); outside the keys the nearest key is copied; an empty track goes straight out.
// Reset is synchronous and active low; the key memory holds no reset value.
// A result waits in the output register; input is taken only in idle, not during a query.
module keyframe_easing_interpolator #(
  parameter int MAX_KEYS = 64,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kei_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kei_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_wdata
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = ($clog2(MAX_KEYS + 1) > 7) ? $clog2(MAX_KEYS + 1) : 7;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_KEYS);
  localparam logic signed [17:0] HALF_C = 18'sd32768;
  localparam logic signed [35:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO = -36'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_COPY, S_DIVGO, S_DIVW, S_CRVGO, S_CRVW, S_BMUL, S_BADD, S_DONE
  } state_t;

  state_t               state_r;
  logic [6:0]           key_count_r;
  logic [2:0]           value_kind_r;
  logic [31:0]          q_r;
  logic [CW-1:0]        ia_r;
  logic                 rd_vld_r;
  logic [CW-1:0]        rd_idx_r;
  kei_pkg::key_entry_t  prev_r, lo_r, hi_r;
  logic [16:0]          t_r;
  logic signed [17:0]   c_r;
  logic [1:0]           lane_r;
  logic signed [50:0]   prod_r;
  logic [3:0][31:0]     res_r;
  logic                 empty_r;
  logic                 out_valid_r;
  kei_pkg::out_item_t   out_data_r;

  logic [CW-1:0]        n_w;
  logic [1:0]           lane_last;
  logic                 in_xfer;
  logic                 mem_we;
  logic                 rd_en;
  kei_pkg::key_entry_t  wr_entry, rd_data;
  logic                 found, at_last;
  logic                 div_done, crv_done;
  logic [16:0]          div_quo;
  logic signed [17:0]   crv_c;
  logic signed [31:0]   a_l, b_l;
  logic signed [32:0]   diff;
  logic signed [51:0]   sum, adj;
  logic signed [35:0]   v;
  logic [31:0]          sat;

  // Counts above the table depth behave as a full table.
  assign n_w = (CW'(key_count_r) > MAX_N) ? MAX_N : CW'(key_count_r);
  assign lane_last = (value_kind_r <= kei_pkg::KIND_VEC4) ? value_kind_r[1:0] : 2'd0;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign mem_we = in_xfer && (in_data.action == kei_pkg::ACT_WRITE) &&
                  (CW'(in_data.key_index) < MAX_N);
  assign wr_entry.key_time = in_data.key_time;
  assign wr_entry.key_curve = in_data.key_curve;
  assign wr_entry.values = {in_data.key_value_3, in_data.key_value_2,
                            in_data.key_value_1, in_data.key_value_0};

  // The scan issues one read per cycle; data comes back in the next cycle. Writes
  // are only taken in idle, so a read never overlaps a write to the same slot.
  assign rd_en = (state_r == S_SCAN) && (ia_r < n_w);

  kei_mem #(
    .DEPTH(MAX_KEYS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .wr_en(mem_we),
    .wr_addr(AW'(in_data.key_index)),
    .wr_data(wr_entry),
    .rd_en(rd_en),
    .rd_addr(ia_r[AW-1:0]),
    .rd_data(rd_data)
  );

  kei_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(state_r == S_DIVGO),
    .num(q_r - lo_r.key_time),
    .den(hi_r.key_time - lo_r.key_time),
    .done(div_done),
    .quo(div_quo)
  );

  kei_curve #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_curve (
    .clk(clk),
    .rst_n(rst_n),
    .start(state_r == S_CRVGO),
    .code(lo_r.key_curve),
    .t(t_r),
    .done(crv_done),
    .c(crv_c)
  );

  assign found = rd_data.key_time >= q_r;
  assign at_last = (rd_idx_r == (n_w - CW'(1)));

  // Blend: a + (b - a) * c / 2^16, truncated toward zero, then saturated.
  assign a_l = lo_r.values[lane_r];
  assign b_l = hi_r.values[lane_r];
  assign diff = {b_l[31], b_l} - {a_l[31], a_l};
  assign sum = {{4{a_l[31]}}, a_l, 16'd0} + 52'(prod_r);
  assign adj = sum[51] ? (sum + 52'sd65535) : sum;
  assign v = 36'(adj >>> 16);
  assign sat = (v > SAT_HI) ? 32'h7fffffff : ((v < SAT_LO) ? 32'h80000000 : v[31:0]);

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      key_count_r <= '0;
      value_kind_r <= kei_pkg::KIND_SCALAR;
      out_valid_r <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kei_pkg::CFG_KEY_COUNT:  key_count_r <= cfg_wdata;
          kei_pkg::CFG_VALUE_KIND: value_kind_r <= cfg_wdata[2:0];
          default: ;
        endcase
      end

      // In the done state the output register is handled below.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r <= rd_en;
      rd_idx_r <= ia_r;
      if (rd_en) begin
        ia_r <= ia_r + CW'(1);
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && (in_data.action == kei_pkg::ACT_QUERY)) begin
            q_r <= in_data.query_time;
            res_r <= '0;
            ia_r <= '0;
            t_r <= 17'd65536;
            if (n_w == '0) begin
              empty_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              empty_r <= 1'b0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_vld_r) begin
            prev_r <= rd_data;
            if (found || at_last) begin
              hi_r <= rd_data;
              if (found && (rd_idx_r != '0)) begin
                lo_r <= prev_r;
                state_r <= S_DIVGO;
              end else begin
                lo_r <= rd_data;
                state_r <= S_COPY;
              end
            end
          end
        end
        S_COPY: begin
          if (value_kind_r == kei_pkg::KIND_BOOL) begin
            res_r[0] <= {31'd0, (lo_r.values[0] != '0)};
          end else begin
            for (int k = 0; k < 4; k++) begin
              if (2'(k) <= lane_last) begin
                res_r[k] <= lo_r.values[k];
              end
            end
          end
          state_r <= S_DONE;
        end
        S_DIVGO: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            t_r <= div_quo;
            state_r <= S_CRVGO;
          end
        end
        S_CRVGO: begin
          state_r <= S_CRVW;
        end
        S_CRVW: begin
          if (crv_done) begin
            c_r <= crv_c;
            lane_r <= 2'd0;
            if (value_kind_r == kei_pkg::KIND_BOOL) begin
              res_r[0] <= {31'd0, (((crv_c < HALF_C) ? lo_r.values[0]
                                                      : hi_r.values[0]) != '0)};
              state_r <= S_DONE;
            end else begin
              state_r <= S_BMUL;
            end
          end
        end
        S_BMUL: begin
          prod_r <= 51'(diff) * 51'(c_r);
          state_r <= S_BADD;
        end
        S_BADD: begin
          res_r[lane_r] <= sat;
          if (lane_r == lane_last) begin
            state_r <= S_DONE;
          end else begin
            lane_r <= lane_r + 2'd1;
            state_r <= S_BMUL;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r.result_0 <= res_r[0];
            out_data_r.result_1 <= res_r[1];
            out_data_r.result_2 <= res_r[2];
            out_data_r.result_3 <= res_r[3];
            out_data_r.track_empty <= empty_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVW))
    else $error("divider finished outside its wait state");

  // The curve unit only finishes while the sequencer waits for it.
  a_crv_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    crv_done |-> (state_r == S_CRVW))
    else $error("curve unit finished outside its wait state");

  // Returned scan data always comes from a valid slot.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && rd_vld_r) |-> (rd_idx_r < n_w))
    else $error("scan read beyond the key count");

  // An empty track answers all zero lanes.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.track_empty) |->
      ((out_data_r.result_0 == '0) && (out_data_r.result_1 == '0) &&
       (out_data_r.result_2 == '0) && (out_data_r.result_3 == '0)))
    else $error("empty track result carries nonzero lanes");

endmodule
